### design/cpv_pkg.sv
// Package for the control packet validator: constants, types and CRC helpers.
`default_nettype none

package cpv_pkg;

   // Item field widths
   localparam int DATA_W = 8;
   localparam int IP_W   = 32;
   localparam int BAUD_W = 21;
   localparam int CRC_W  = 32;
   localparam int CNT_W  = 5;

   // Frame layout
   localparam int PKT_BYTES = 20;
   localparam logic [CNT_W-1:0] PKT_LEN   = 5'd20;
   localparam logic [CNT_W-1:0] COUNT_SAT = 5'd21;
   localparam logic [CNT_W-1:0] CRC_SPAN  = 5'd16;
   localparam int BAUD_POS  = 8;
   localparam int FLAGS_POS = 12;
   localparam int CRC_POS   = 16;

   // Magic "PSB1"
   localparam logic [DATA_W-1:0] MAGIC_0 = 8'h50;
   localparam logic [DATA_W-1:0] MAGIC_1 = 8'h53;
   localparam logic [DATA_W-1:0] MAGIC_2 = 8'h42;
   localparam logic [DATA_W-1:0] MAGIC_3 = 8'h31;

   // CRC-32, reflected
   localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;
   localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFFFFFF;

   // Supported baud rates
   localparam logic [BAUD_W-1:0] BAUD_RESET = 21'd115200;
   localparam logic [BAUD_W-1:0] BAUD_230K  = 21'd230400;
   localparam logic [BAUD_W-1:0] BAUD_518K  = 21'd518400;
   localparam logic [BAUD_W-1:0] BAUD_691K  = 21'd691200;
   localparam logic [BAUD_W-1:0] BAUD_1M    = 21'd1036800;
   localparam logic [BAUD_W-1:0] BAUD_2M    = 21'd2073600;

   typedef enum logic [1:0] {
      VERDICT_ACCEPT    = 2'd0,
      VERDICT_DUPLICATE = 2'd1,
      VERDICT_MALFORMED = 2'd2
   } verdict_type;

   // One byte handed to the frame checker
   typedef struct packed {
      logic              fire;
      logic [DATA_W-1:0] data_byte;
      logic              byte_last;
      logic [IP_W-1:0]   sender_ip;
      logic              session_active;
      logic [IP_W-1:0]   owner_ip;
   } step_type;

   // Verdict for the frame that ends with the current byte
   typedef struct packed {
      verdict_type       verdict;
      logic              abort_request;
      logic              baud_changed;
      logic [BAUD_W-1:0] new_baud;
   } result_type;

   // One byte through the reflected CRC-32, bit at a time
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_val,
                                                 input logic [DATA_W-1:0] data);
      logic [CRC_W-1:0] c;
      c = crc_val ^ {{(CRC_W-DATA_W){1'b0}}, data};
      for (int i = 0; i < DATA_W; i++) begin
         c = (c >> 1) ^ (CRC_POLY & {CRC_W{c[0]}});
      end
      return c;
   endfunction

   function automatic logic baud_ok(input logic [31:0] b);
      logic [BAUD_W-1:0] lo;
      lo = b[BAUD_W-1:0];
      return (b[31:BAUD_W] == '0) &&
             ((lo == BAUD_RESET) || (lo == BAUD_230K) || (lo == BAUD_518K) ||
              (lo == BAUD_691K) || (lo == BAUD_1M) || (lo == BAUD_2M));
   endfunction

endpackage

`default_nettype wire

### design/cpv_if.sv
// Handshake interfaces for the validator's byte input and verdict output.
`default_nettype none

interface cpv_req_if;
   import cpv_pkg::*;
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_byte;
   logic              byte_last;
   logic [IP_W-1:0]   sender_ip;
   logic              session_active;
   logic [IP_W-1:0]   owner_ip;

   modport source (output valid, data_byte, byte_last, sender_ip, session_active,
                   owner_ip, input ready);
   modport sink   (input valid, data_byte, byte_last, sender_ip, session_active,
                   owner_ip, output ready);
endinterface

interface cpv_rsp_if;
   import cpv_pkg::*;
   logic              valid;
   logic              ready;
   verdict_type       verdict;
   logic              abort_request;
   logic              baud_changed;
   logic [BAUD_W-1:0] new_baud;

   modport source (output valid, verdict, abort_request, baud_changed, new_baud,
                   input ready);
   modport sink   (input valid, verdict, abort_request, baud_changed, new_baud,
                   output ready);
endinterface

`default_nettype wire

### design/control_packet_validator_top.sv
// Top level of the control packet validator: input stage, checker, result register.
//
// Bytes of a control datagram enter on req_ch, one per item, with byte_last set
// on the final byte; sender_ip, session_active and owner_ip are sampled there.
// Each datagram yields exactly one verdict item on rsp_ch (accepted, duplicate
// or malformed), with abort_request, baud_changed and the baud now in effect.
// Bytes other than the last produce no output item.
//
// A byte is first held in the input register; the verdict of the final byte is
// then captured in the result register, which drives rsp_ch.valid.
// Throughput: one byte per cycle. The CRC step, store write and cache compare
// for a byte all happen in the same cycle, between the two registers.
// When rsp_ch stalls, non-final bytes keep flowing; a final byte waits in the
// input register until the pending verdict is taken, and req_ch.ready drops.
// Reset (synchronous) empties both registers, restarts the frame, clears the
// packet cache and returns the baud to 115200.
`default_nettype none

module control_packet_validator_top (
   input wire logic clock,
   input wire logic reset,
   cpv_req_if.sink   req_ch,
   cpv_rsp_if.source rsp_ch
);
   import cpv_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [DATA_W-1:0] in_data_ff;
   logic              in_last_ff;
   logic [IP_W-1:0]   in_sender_ff;
   logic              in_session_ff;
   logic [IP_W-1:0]   in_owner_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_data_ff;
   logic              req_fire, advance;
   step_type          step;
   result_type        result;

   // Handshake: a final byte moves on only when the result register is free or being taken
   assign advance  = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_fire = req_ch.valid && req_ch.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff    <= req_ch.data_byte;
         in_last_ff    <= req_ch.byte_last;
         in_sender_ff  <= req_ch.sender_ip;
         in_session_ff <= req_ch.session_active;
         in_owner_ff   <= req_ch.owner_ip;
      end
   end

   assign step = '{fire:           advance,
                   data_byte:      in_data_ff,
                   byte_last:      in_last_ff,
                   sender_ip:      in_sender_ff,
                   session_active: in_session_ff,
                   owner_ip:       in_owner_ff};

   cpv_frame_check u_frame_check (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .result (result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (advance && in_last_ff) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.verdict       = rsp_data_ff.verdict;
   assign rsp_ch.abort_request = rsp_data_ff.abort_request;
   assign rsp_ch.baud_changed  = rsp_data_ff.baud_changed;
   assign rsp_ch.new_baud      = rsp_data_ff.new_baud;

endmodule

`default_nettype wire

### design/cpv_frame_check.sv
// Frame state, packet store, cache and verdict logic of the validator.
`default_nettype none

module cpv_frame_check (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cpv_pkg::step_type  step,
   output cpv_pkg::result_type     result
);
   import cpv_pkg::*;

   logic [CNT_W-1:0]  count_ff,  count_in;
   logic [CRC_W-1:0]  crc_ff,    crc_in;
   logic              mismatch_ff, mismatch_in;
   logic              cache_valid_ff;
   logic [IP_W-1:0]   cache_sender_ff;
   logic [BAUD_W-1:0] baud_ff;
   logic [DATA_W-1:0] store_ff [PKT_BYTES];
   logic [DATA_W-1:0] cache_ff [PKT_BYTES];

   logic              in_frame;
   logic [DATA_W-1:0] store_view [PKT_BYTES];
   logic [31:0]       rx_baud, rx_flags, rx_crc;
   logic              magic_ok, content_ok, owner_ok, is_dup, accept;

   // Byte position, CRC and cache compare including the current byte
   always_comb begin
      in_frame    = count_ff < PKT_LEN;
      count_in    = (count_ff < COUNT_SAT) ? count_ff + 5'd1 : count_ff;
      crc_in      = (count_ff < CRC_SPAN) ? crc_byte(crc_ff, step.data_byte) : crc_ff;
      mismatch_in = mismatch_ff;
      if (in_frame && (cache_ff[count_ff] != step.data_byte)) begin
         mismatch_in = 1'b1;
      end
      for (int i = 0; i < PKT_BYTES; i++) begin
         store_view[i] = (in_frame && (count_ff == CNT_W'(i))) ? step.data_byte
                                                               : store_ff[i];
      end
   end

   // Field decode and verdict on the final byte
   always_comb begin
      rx_baud  = {store_view[BAUD_POS+3], store_view[BAUD_POS+2],
                  store_view[BAUD_POS+1], store_view[BAUD_POS]};
      rx_flags = {store_view[FLAGS_POS+3], store_view[FLAGS_POS+2],
                  store_view[FLAGS_POS+1], store_view[FLAGS_POS]};
      rx_crc   = {store_view[CRC_POS+3], store_view[CRC_POS+2],
                  store_view[CRC_POS+1], store_view[CRC_POS]};
      magic_ok = (store_view[0] == MAGIC_0) && (store_view[1] == MAGIC_1) &&
                 (store_view[2] == MAGIC_2) && (store_view[3] == MAGIC_3);
      content_ok = magic_ok && (rx_crc == ~crc_in) && (rx_flags[31:1] == '0) &&
                   baud_ok(rx_baud);
      owner_ok = !step.session_active || (step.sender_ip == step.owner_ip);
      is_dup   = cache_valid_ff && (cache_sender_ff == step.sender_ip) && !mismatch_in;

      result.abort_request = 1'b0;
      result.baud_changed  = 1'b0;
      result.new_baud      = baud_ff;
      accept               = 1'b0;
      priority if (count_in != PKT_LEN) begin
         result.verdict = VERDICT_MALFORMED;
      end else if (is_dup) begin
         result.verdict = VERDICT_DUPLICATE;
      end else if (!content_ok || !owner_ok) begin
         result.verdict = VERDICT_MALFORMED;
      end else begin
         result.verdict       = VERDICT_ACCEPT;
         accept               = step.byte_last;
         result.abort_request = rx_flags[0];
         result.baud_changed  = rx_baud[BAUD_W-1:0] != baud_ff;
         result.new_baud      = rx_baud[BAUD_W-1:0];
      end
   end

   // Frame control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         crc_ff         <= CRC_INIT;
         mismatch_ff    <= 1'b0;
         cache_valid_ff <= 1'b0;
         baud_ff        <= BAUD_RESET;
      end else if (step.fire) begin
         if (step.byte_last) begin
            count_ff    <= '0;
            crc_ff      <= CRC_INIT;
            mismatch_ff <= 1'b0;
         end else begin
            count_ff    <= count_in;
            crc_ff      <= crc_in;
            mismatch_ff <= mismatch_in;
         end
         if (accept) begin
            cache_valid_ff <= 1'b1;
            baud_ff        <= rx_baud[BAUD_W-1:0];
         end
      end
   end

   // Packet store and cache; cache content only counts once cache_valid is set
   always_ff @(posedge clock) begin
      if (step.fire) begin
         for (int i = 0; i < PKT_BYTES; i++) begin
            store_ff[i] <= store_view[i];
         end
         if (accept) begin
            cache_sender_ff <= step.sender_ip;
            for (int i = 0; i < PKT_BYTES; i++) begin
               cache_ff[i] <= store_view[i];
            end
         end
      end
   end

endmodule

`default_nettype wire

### design/cpv_checker.sv
// Port-level assertions for the control packet validator, bound to the top level.
`default_nettype none

module cpv_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire cpv_pkg::verdict_type       verdict,
   input wire logic                       abort_request,
   input wire logic                       baud_changed,
   input wire logic [cpv_pkg::BAUD_W-1:0] new_baud
);
   import cpv_pkg::*;

   logic [BAUD_W-1:0] last_baud_ff;

   // Baud in effect as told by the last delivered verdict
   always_ff @(posedge clock) begin
      if (reset) begin
         last_baud_ff <= BAUD_RESET;
      end else if (rsp_valid && rsp_ready) begin
         last_baud_ff <= new_baud;
      end
   end

   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("verdict valid right after reset");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("verdict item dropped while stalled");

   a_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(verdict) && $stable(abort_request) &&
                                  $stable(baud_changed) && $stable(new_baud))
      else $error("verdict payload changed while stalled");

   a_baud_track: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |-> baud_changed == (new_baud != last_baud_ff))
      else $error("baud_changed disagrees with baud history");

endmodule

bind control_packet_validator_top cpv_checker u_cpv_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .verdict       (rsp_ch.verdict),
   .abort_request (rsp_ch.abort_request),
   .baud_changed  (rsp_ch.baud_changed),
   .new_baud      (rsp_ch.new_baud)
);

`default_nettype wire
